/* rtl/srbp_pkg.sv */
// ============================================================================
// srbp_pkg - shared definitions for the sensor record bit packer
// Field widths, operation and register codes, reset values and derived sizes.
// ============================================================================
package srbp_pkg;

    // Field widths in the packed stream
    localparam int TEMP_BITS = 12;
    localparam int PRES_BITS = 14;
    localparam int HUM_BITS  = 11;

    localparam logic [15:0] TEMP_MASK = 16'((32'd1 << TEMP_BITS) - 32'd1);
    localparam logic [15:0] PRES_MASK = 16'((32'd1 << PRES_BITS) - 32'd1);
    localparam logic [15:0] HUM_MASK  = 16'((32'd1 << HUM_BITS) - 32'd1);

    // Header byte layout
    localparam logic [7:0] HDR_TEMP   = 8'd128;
    localparam logic [7:0] HDR_PRES   = 8'd64;
    localparam logic [7:0] HDR_HUM    = 8'd32;
    localparam logic [7:0] HDR_UPDATE = 8'd2;

    // Bit accumulator: pending bits, header and all three fields
    localparam int PEND_BITS   = 7;
    localparam int ACC_W       = PEND_BITS + 8 + TEMP_BITS + PRES_BITS + HUM_BITS;
    localparam int N_W         = $clog2(ACC_W + 1);
    localparam int FRAME_BYTES = ACC_W / 8;
    localparam int FRAME_W     = FRAME_BYTES * 8;
    localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

    typedef enum logic [1:0] {
        OP_FULL   = 2'd0,
        OP_UPDATE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_TEMP_MIN = 2'd0,
        CFG_PRES_MIN = 2'd1,
        CFG_HUM_MIN  = 2'd2
    } cfg_idx_t;

    localparam logic [15:0] TEMP_MIN_RST = 16'hFE70;   // -400
    localparam logic [15:0] PRES_MIN_RST = 16'd3000;
    localparam logic [15:0] HUM_MIN_RST  = 16'd0;

    typedef struct packed {
        logic        present;
        logic [15:0] val;
    } field_t;

endpackage

/* rtl/sensor_record_bit_packer.sv */
// ============================================================================
// sensor_record_bit_packer - weather record to MSB-first byte stream
// Scales readings against configured minimums, builds a header and packs
// present fields into a continuous bit stream, one byte per output item.
// ============================================================================
// An item is registered on input; from that register its whole bit string
// (leftover bits, header, present fields) is formed and, once the frame can
// take it, loaded into a byte frame, which shifts out one byte per cycle
// while out_stall is low. A record yields 1 to 6 bytes, a flush 0 or 1, an
// undefined operation none. The input register takes a new item every cycle
// as long as each item yields at most one byte and the output is not
// stalled; otherwise the output frame sets the pace, and an item waits until
// the last byte of the one before is taken. References and leftover bits are
// updated as each item enters the frame, so records follow back to back.
module sensor_record_bit_packer (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    // input items
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] temperature_tenths,
    input  logic [15:0] pressure_tenths,
    input  logic [15:0] humidity_tenths,
    // result items
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  packed_byte,
    output logic        last_byte
);

    // configuration registers
    logic [15:0] temp_min_reg, pres_min_reg, hum_min_reg;

    // input register
    logic        in_vld_reg, in_vld_next;
    logic [1:0]  op_reg;
    logic [15:0] temp_reg, pres_reg, hum_reg;

    // stream state
    logic [srbp_pkg::PEND_BITS-1:0] pend_reg, pend_next;
    logic [2:0]                     pcnt_reg, pcnt_next;
    logic [15:0] ref_t_reg, ref_p_reg, ref_h_reg;
    logic [15:0] ref_t_next, ref_p_next, ref_h_next;

    // output frame
    logic [srbp_pkg::FRAME_W-1:0] frm_data_reg, frm_data_next;
    logic [srbp_pkg::CNT_W-1:0]   frm_cnt_reg, frm_cnt_next;

    // datapath
    logic signed [16:0]         s_t, s_p, s_h;
    srbp_pkg::field_t           f_t, f_p, f_h;
    logic                       is_full;
    logic [7:0]                 header;
    logic [srbp_pkg::ACC_W-1:0] acc, aligned;
    logic [srbp_pkg::N_W-1:0]   n;
    logic [srbp_pkg::CNT_W-1:0] n_bytes;
    logic [2:0]                 rem;
    logic [srbp_pkg::PEND_BITS-1:0] rem_mask;
    logic                       out_fire, load_ok, consume, in_fire;

    function automatic srbp_pkg::field_t field_calc(
        input logic               full,
        input logic signed [16:0] s,
        input logic [15:0]        ref_val,
        input logic [15:0]        mask
    );
        srbp_pkg::field_t   f;
        logic signed [17:0] d;
        d = {s[16], s} - $signed({2'b00, ref_val});
        if (full)
        begin
            f.present = ~s[16];
            f.val     = (s[15:0] > mask) ? mask : s[15:0];
            if (s[16])
            begin
                f.val = 16'd0;
            end
        end
        else
        begin
            f.present = (d != 18'sd0);
            f.val     = d[15:0] & mask;
        end
        return f;
    endfunction

    // ---------------------------------------------------------------- config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_min_reg <= srbp_pkg::TEMP_MIN_RST;
            pres_min_reg <= srbp_pkg::PRES_MIN_RST;
            hum_min_reg  <= srbp_pkg::HUM_MIN_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                srbp_pkg::CFG_TEMP_MIN: temp_min_reg <= cfg_data;
                srbp_pkg::CFG_PRES_MIN: pres_min_reg <= cfg_data;
                srbp_pkg::CFG_HUM_MIN:  hum_min_reg  <= cfg_data;
                default:                ;
            endcase
        end
    end

    // -------------------------------------------------------------- datapath
    always_comb
    begin
        is_full = (op_reg == srbp_pkg::OP_FULL);
        s_t = $signed({temp_reg[15], temp_reg}) - $signed({temp_min_reg[15], temp_min_reg});
        s_p = $signed({pres_reg[15], pres_reg}) - $signed({pres_min_reg[15], pres_min_reg});
        s_h = $signed({hum_reg[15], hum_reg}) - $signed({hum_min_reg[15], hum_min_reg});
        f_t = field_calc(is_full, s_t, ref_t_reg, srbp_pkg::TEMP_MASK);
        f_p = field_calc(is_full, s_p, ref_p_reg, srbp_pkg::PRES_MASK);
        f_h = field_calc(is_full, s_h, ref_h_reg, srbp_pkg::HUM_MASK);

        header = (f_t.present ? srbp_pkg::HDR_TEMP : 8'd0)
               | (f_p.present ? srbp_pkg::HDR_PRES : 8'd0)
               | (f_h.present ? srbp_pkg::HDR_HUM  : 8'd0)
               | (is_full ? 8'd0 : srbp_pkg::HDR_UPDATE);

        acc        = srbp_pkg::ACC_W'(pend_reg);
        n          = srbp_pkg::N_W'(pcnt_reg);
        pend_next  = pend_reg;
        pcnt_next  = pcnt_reg;
        ref_t_next = ref_t_reg;
        ref_p_next = ref_p_reg;
        ref_h_next = ref_h_reg;
        n_bytes    = '0;
        rem        = 3'd0;
        rem_mask   = '0;

        case (op_reg)
            srbp_pkg::OP_FULL, srbp_pkg::OP_UPDATE:
            begin
                acc = (acc << 8) | srbp_pkg::ACC_W'(header);
                n   = n + srbp_pkg::N_W'(8);
                if (f_t.present)
                begin
                    acc = (acc << srbp_pkg::TEMP_BITS)
                        | srbp_pkg::ACC_W'(f_t.val[srbp_pkg::TEMP_BITS-1:0]);
                    n   = n + srbp_pkg::N_W'(srbp_pkg::TEMP_BITS);
                end
                if (f_p.present)
                begin
                    acc = (acc << srbp_pkg::PRES_BITS)
                        | srbp_pkg::ACC_W'(f_p.val[srbp_pkg::PRES_BITS-1:0]);
                    n   = n + srbp_pkg::N_W'(srbp_pkg::PRES_BITS);
                end
                if (f_h.present)
                begin
                    acc = (acc << srbp_pkg::HUM_BITS)
                        | srbp_pkg::ACC_W'(f_h.val[srbp_pkg::HUM_BITS-1:0]);
                    n   = n + srbp_pkg::N_W'(srbp_pkg::HUM_BITS);
                end
                n_bytes   = srbp_pkg::CNT_W'(n >> 3);
                rem       = n[2:0];
                rem_mask  = ~({srbp_pkg::PEND_BITS{1'b1}} << rem);
                pend_next = acc[srbp_pkg::PEND_BITS-1:0] & rem_mask;
                pcnt_next = rem;
                if (is_full)
                begin
                    if (f_t.present) ref_t_next = f_t.val;
                    if (f_p.present) ref_p_next = f_p.val;
                    if (f_h.present) ref_h_next = f_h.val;
                end
            end
            srbp_pkg::OP_FLUSH:
            begin
                // leftover bits go out MSB-aligned, zero padded
                n_bytes   = (pcnt_reg != 3'd0) ? srbp_pkg::CNT_W'(1) : '0;
                pend_next = '0;
                pcnt_next = 3'd0;
            end
            default:
            begin
                n_bytes = '0;
            end
        endcase

        aligned = acc << (srbp_pkg::N_W'(srbp_pkg::ACC_W) - n);
    end

    // ------------------------------------------------------------- handshake
    assign out_valid   = (frm_cnt_reg != '0);
    assign packed_byte = frm_data_reg[srbp_pkg::FRAME_W-1 -: 8];
    assign last_byte   = (frm_cnt_reg == srbp_pkg::CNT_W'(1));
    assign out_fire    = out_valid && !out_stall;
    assign load_ok     = (frm_cnt_reg == '0) || (last_byte && !out_stall);
    // items that yield no byte never wait on the frame
    assign consume     = in_vld_reg && (load_ok || (n_bytes == '0));
    assign in_stall    = in_vld_reg && !consume;
    assign in_fire     = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (in_fire)
        begin
            in_vld_next = 1'b1;
        end
        else if (consume)
        begin
            in_vld_next = 1'b0;
        end

        frm_data_next = frm_data_reg;
        frm_cnt_next  = frm_cnt_reg;
        if (out_fire)
        begin
            frm_data_next = frm_data_reg << 8;
            frm_cnt_next  = frm_cnt_reg - srbp_pkg::CNT_W'(1);
        end
        if (consume && (n_bytes != '0))
        begin
            frm_data_next = aligned[srbp_pkg::ACC_W-1 -: srbp_pkg::FRAME_W];
            frm_cnt_next  = n_bytes;
        end
    end

    // ------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            frm_cnt_reg <= '0;
            pend_reg    <= '0;
            pcnt_reg    <= 3'd0;
            ref_t_reg   <= 16'd0;
            ref_p_reg   <= 16'd0;
            ref_h_reg   <= 16'd0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            frm_cnt_reg <= frm_cnt_next;
            if (consume)
            begin
                pend_reg  <= pend_next;
                pcnt_reg  <= pcnt_next;
                ref_t_reg <= ref_t_next;
                ref_p_reg <= ref_p_next;
                ref_h_reg <= ref_h_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        frm_data_reg <= frm_data_next;
        if (in_fire)
        begin
            op_reg   <= operation;
            temp_reg <= temperature_tenths;
            pres_reg <= pressure_tenths;
            hum_reg  <= humidity_tenths;
        end
    end

    // ------------------------------------------------------------ assertions
    a_frame_bound: assert property (@(posedge clk) disable iff (!rst_n)
        frm_cnt_reg <= srbp_pkg::CNT_W'(srbp_pkg::FRAME_BYTES))
        else $error("frame byte count out of range");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && (n_bytes != '0)) |-> (frm_cnt_reg == '0 || (last_byte && !out_stall)))
        else $error("frame loaded while bytes still pending");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (consume && op_reg == srbp_pkg::OP_FLUSH) |=> (pcnt_reg == 3'd0 && pend_reg == '0))
        else $error("flush left bits pending");

    a_pend_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_reg & ({srbp_pkg::PEND_BITS{1'b1}} << pcnt_reg)) == '0)
        else $error("stale bits above pending count");

endmodule
